### rtl/core/htwd_pkg.sv
package htwd_pkg;

   // widths fixed by the word format
   localparam int INDEX_W  = 10;
   localparam int CHILD_W  = 11;
   localparam int SYMBOL_W = 11;
   localparam int COUNT_W  = 11;

   // default table depth
   localparam int NODES_DEFAULT = 1024;

   // depth of the queue between front and back (power of two)
   localparam int QDEPTH = 2;

   // reset value of the node count register
   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(1);

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_SYMBOL = 2'd0,
      ST_FINISH = 2'd1,
      ST_BADREF = 2'd2
   } status_type;

   // one classified request word as it waits in the queue
   typedef struct packed {
      op_type               op;
      logic                 wr_in_range;
      logic [INDEX_W-1:0]   node_index;
      logic [CHILD_W-1:0]   left_child;
      logic [CHILD_W-1:0]   right_child;
      logic                 code_bit;
      logic                 last_bit;
   } item_type;

endpackage

### rtl/core/htwd_ram.sv
module htwd_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, new data on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/htwd_front.sv
module htwd_front #(
   parameter int NODES = htwd_pkg::NODES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [htwd_pkg::INDEX_W-1:0]      req_node_index,
   input  logic signed [htwd_pkg::CHILD_W-1:0] req_left_child,
   input  logic signed [htwd_pkg::CHILD_W-1:0] req_right_child,
   input  logic                              req_code_bit,
   input  logic                              req_last_bit,
   output logic                              head_valid,
   output htwd_pkg::item_type                head,
   input  logic                              head_pop
);
   import htwd_pkg::*;

   localparam int AW = $clog2(NODES);
   localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
   localparam logic [IW:0] NODES_W = (IW+1)'(NODES);
   localparam int PW = $clog2(QDEPTH);

   item_type          entry_ff [QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   item_type          item;
   logic              push;

   // classify the incoming word
   always_comb begin
      item.op          = op_type'(req_func);
      item.wr_in_range = ({1'b0, IW'(req_node_index)} < NODES_W);
      item.node_index  = req_node_index;
      item.left_child  = req_left_child;
      item.right_child = req_right_child;
      item.code_bit    = req_code_bit;
      item.last_bit    = req_last_bit;
   end

   assign req_stall = (count_ff == (PW+1)'(QDEPTH));
   assign push      = req_valid && !req_stall;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

endmodule

### rtl/core/htwd_back.sv
module htwd_back #(
   parameter int NODES = htwd_pkg::NODES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  htwd_pkg::item_type                head,
   output logic                              head_pop,
   input  logic                              csr_wr_en,
   input  logic [htwd_pkg::COUNT_W-1:0]      csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [htwd_pkg::SYMBOL_W-1:0]     rsp_symbol,
   output logic [1:0]                        rsp_status
);
   import htwd_pkg::*;

   localparam int AW = $clog2(NODES);
   localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
   localparam logic [IW:0] NODES_W = (IW+1)'(NODES);

   logic [COUNT_W-1:0]  node_count_ff;
   logic [INDEX_W-1:0]  walk_ff, walk_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0] symbol_ff, symbol_in;
   status_type          status_ff, status_in;
   logic                out_free, take, emit;
   logic                bad_ref;
   logic [CHILD_W-1:0]  left_rd, right_rd, child;
   logic                ram_we;
   logic [IW-1:0]       wr_ext, rd_ext;

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // take the head word when the output register can hold a result
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = head_valid && out_free;
   assign head_pop = take;

   // table writes
   assign ram_we = take && (head.op == OP_WRITE) && head.wr_in_range;
   assign wr_ext = IW'(head.node_index);

   // one tree step: read data holds the entry of the current node
   always_comb begin
      bad_ref = ({1'b0, walk_ff} >= node_count_ff) ||
                ({1'b0, IW'(walk_ff)} >= NODES_W);
      child   = head.code_bit ? right_rd : left_rd;
      walk_in   = walk_ff;
      emit      = 1'b0;
      symbol_in = '0;
      status_in = ST_SYMBOL;
      if (take && (head.op == OP_DECODE)) begin
         if (bad_ref) begin
            walk_in   = '0;
            emit      = 1'b1;
            status_in = ST_BADREF;
         end else if (child[CHILD_W-1]) begin
            // leaf: symbol is the negated child
            walk_in   = '0;
            emit      = 1'b1;
            symbol_in = SYMBOL_W'(12'h800 - {1'b0, child});
         end else if (head.last_bit) begin
            walk_in   = '0;
            emit      = 1'b1;
            status_in = ST_FINISH;
         end else begin
            walk_in   = child[INDEX_W-1:0];
         end
      end
   end

   assign rd_ext = IW'(walk_in);

   htwd_ram #(
      .WIDTH (CHILD_W),
      .DEPTH (NODES)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ext[AW-1:0]),
      .wr_data (head.left_child),
      .rd_addr (rd_ext[AW-1:0]),
      .rd_data (left_rd)
   );

   htwd_ram #(
      .WIDTH (CHILD_W),
      .DEPTH (NODES)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ext[AW-1:0]),
      .wr_data (head.right_child),
      .rd_addr (rd_ext[AW-1:0]),
      .rd_data (right_rd)
   );

   // walk position
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= '0;
      end else begin
         walk_ff <= walk_in;
      end
   end

   // result register
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         symbol_ff <= symbol_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = symbol_ff;
   assign rsp_status = status_ff;

   // non-symbol results carry a zero symbol
   a_status_zero_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != ST_SYMBOL)) |-> (symbol_ff == '0))
      else $error("nonzero symbol on a status word");

   // every result sends the walk back to the root
   a_result_to_root: assert property (@(posedge clock) disable iff (reset)
      emit |=> (walk_ff == '0))
      else $error("walk not at root after a result");

   // a held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !take)
      else $error("queue drained while a result was stalled");

endmodule

### rtl/core/huffman_tree_walk_decoder_unit.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   func, node_index, left/right_child, code/last_bit
// rsp       out        rsp_valid/rsp_stall   symbol, status
// csr       in         csr_wr_en             node_count
//
// One word per cycle sustained while rsp is not stalled: the next-node loop is one table
// read a cycle, registered read data picking the child that addresses the following read.
// A request word is registered in the queue, its result in the result register, then shown on rsp.
// Synchronous reset puts the walk at the root and node_count at one; tables are not cleared.
// A two-word queue lets req keep flowing while rsp is stalled, until the queue fills.
module huffman_tree_walk_decoder_unit #(
   parameter int NODES = htwd_pkg::NODES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [htwd_pkg::INDEX_W-1:0]        req_node_index,
   input  logic signed [htwd_pkg::CHILD_W-1:0] req_left_child,
   input  logic signed [htwd_pkg::CHILD_W-1:0] req_right_child,
   input  logic                                req_code_bit,
   input  logic                                req_last_bit,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [htwd_pkg::SYMBOL_W-1:0]       rsp_symbol,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_wr_en,
   input  logic [htwd_pkg::COUNT_W-1:0]        csr_wr_data
);
   import htwd_pkg::*;

   logic     head_valid;
   item_type head;
   logic     head_pop;

   htwd_front #(
      .NODES (NODES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_node_index  (req_node_index),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_code_bit    (req_code_bit),
      .req_last_bit    (req_last_bit),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop)
   );

   htwd_back #(
      .NODES (NODES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_symbol  (rsp_symbol),
      .rsp_status  (rsp_status)
   );

endmodule
